@@ sv/data_run_list_decoder_top_defines.svh @@
// assertion macros shared by the run list decoder
`ifndef DATA_RUN_LIST_DECODER_TOP_DEFINES_SVH
`define DATA_RUN_LIST_DECODER_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define DRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("run list decoder check failed");

// next-cycle implication, masked during reset
`define DRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("run list decoder check failed");

`endif

@@ sv/drl_pkg.sv @@
package drl_pkg;

    localparam int BYTE_W  = 8;
    localparam int START_W = 63;
    localparam int COUNT_W = 64;
    localparam int CODE_W  = 3;

    localparam logic [CODE_W-1:0] END_RUN       = 3'd0;
    localparam logic [CODE_W-1:0] END_ZERO_HEAD = 3'd1;
    localparam logic [CODE_W-1:0] END_ZERO_LEN  = 3'd2;
    localparam logic [CODE_W-1:0] END_TRUNC     = 3'd3;
    localparam logic [CODE_W-1:0] END_BUF       = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] run_start;
        logic [COUNT_W-1:0] run_length;
        logic [CODE_W-1:0]  end_code;
        logic               list_done;
    } t_result;

endpackage

@@ sv/drl_core.sv @@
module drl_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [drl_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_last_byte,
    output drl_pkg::t_result            o_res
);
    import drl_pkg::*;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_LEN  = 2'd1,
        PH_OFF  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    localparam logic [63:0] ALL_ONES = '1;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_len_left, n_len_left;
    logic [3:0]  r_off_left, n_off_left;
    logic [3:0]  r_idx, n_idx;
    logic [63:0] r_len_acc, n_len_acc;
    logic [63:0] r_off_acc, n_off_acc;
    logic [63:0] r_prev, n_prev;

    logic [63:0] w_field_acc;
    logic [3:0]  w_left;
    logic [63:0] w_taken;
    logic [3:0]  w_idx_next;
    logic [3:0]  w_left_dec;
    logic [63:0] w_sign_mask;
    logic [63:0] w_delta;
    logic [63:0] w_sum;
    logic [63:0] w_count;
    logic        do_end;
    logic        do_finish;
    logic        do_clear;
    logic [CODE_W-1:0] end_code;

    // or the byte into its lane; bytes past the eighth fall away
    function automatic logic [63:0] f_take(input logic [63:0] acc, input logic [3:0] idx,
                                           input logic [7:0] b);
        logic [63:0] r;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            if (idx == 4'(k)) begin
                r[k*8 +: 8] = r[k*8 +: 8] | b;
            end
        end
        return r;
    endfunction

    always_comb begin
        w_field_acc = (r_phase == PH_LEN) ? r_len_acc : r_off_acc;
        w_left      = (r_phase == PH_LEN) ? r_len_left : r_off_left;
        w_taken     = f_take(w_field_acc, r_idx, i_data_byte);
        w_idx_next  = (r_idx != 4'd15) ? r_idx + 4'd1 : r_idx;
        w_left_dec  = w_left - 4'd1;
        // sign extension from the last offset byte, short offsets only
        w_sign_mask = '0;
        if (i_data_byte[7] && w_idx_next < 4'd8) begin
            for (int k = 1; k < 8; k++) begin
                if (w_idx_next == 4'(k)) begin
                    w_sign_mask = ALL_ONES << (8 * k);
                end
            end
        end
        w_delta = (r_phase == PH_OFF) ? (w_taken | w_sign_mask) : '0;
        w_sum   = r_prev + w_delta;
        w_count = (r_phase == PH_LEN) ? w_taken : r_len_acc;
    end

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_off_left = r_off_left;
        n_idx      = r_idx;
        n_len_acc  = r_len_acc;
        n_off_acc  = r_off_acc;
        n_prev     = r_prev;
        do_end     = 1'b0;
        do_finish  = 1'b0;
        do_clear   = 1'b0;
        end_code   = END_RUN;
        o_res      = '0;

        if (i_fire) begin
            unique case (r_phase)
                PH_HEAD: begin
                    if (i_data_byte == '0) begin
                        do_end   = 1'b1;
                        end_code = END_ZERO_HEAD;
                    end else if (i_data_byte[3:0] == 4'd0) begin
                        do_end   = 1'b1;
                        end_code = END_ZERO_LEN;
                    end else if (i_last_byte) begin
                        do_end   = 1'b1;
                        end_code = END_TRUNC;
                    end else begin
                        n_len_left = i_data_byte[3:0];
                        n_off_left = i_data_byte[7:4];
                        n_idx      = '0;
                        n_len_acc  = '0;
                        n_off_acc  = '0;
                        n_phase    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len_acc  = w_taken;
                    n_len_left = w_left_dec;
                    n_idx      = w_idx_next;
                    if (w_left_dec == 4'd0 && r_off_left == 4'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        if (w_left_dec == 4'd0) begin
                            n_phase = PH_OFF;
                            n_idx   = '0;
                        end
                        if (i_last_byte) begin
                            do_end   = 1'b1;
                            end_code = END_TRUNC;
                        end
                    end
                end
                PH_OFF: begin
                    n_off_acc  = w_taken;
                    n_off_left = w_left_dec;
                    n_idx      = w_idx_next;
                    if (w_left_dec == 4'd0) begin
                        do_finish = 1'b1;
                    end else if (i_last_byte) begin
                        do_end   = 1'b1;
                        end_code = END_TRUNC;
                    end
                end
                PH_DONE: begin
                    do_clear = i_last_byte;
                end
                default: begin
                    n_phase = PH_HEAD;
                end
            endcase

            if (do_finish) begin
                n_prev  = w_sum;
                n_phase = PH_HEAD;
                n_idx   = '0;
                if (!w_sum[63]) begin
                    o_res.valid      = 1'b1;
                    o_res.run_start  = w_sum[START_W-1:0];
                    o_res.run_length = w_count;
                    o_res.end_code   = END_RUN;
                    o_res.list_done  = i_last_byte;
                    do_clear         = i_last_byte;
                end else if (i_last_byte) begin
                    // negative start on the final byte turns into a buffer end
                    do_end   = 1'b1;
                    end_code = END_BUF;
                end
            end

            if (do_end) begin
                o_res.valid     = 1'b1;
                o_res.end_code  = end_code;
                o_res.list_done = 1'b1;
                if (i_last_byte) begin
                    do_clear = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end

            if (do_clear) begin
                n_phase    = PH_HEAD;
                n_len_left = '0;
                n_off_left = '0;
                n_idx      = '0;
                n_len_acc  = '0;
                n_off_acc  = '0;
                n_prev     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD;
            r_len_left <= '0;
            r_off_left <= '0;
            r_idx      <= '0;
            r_len_acc  <= '0;
            r_off_acc  <= '0;
            r_prev     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_off_left <= n_off_left;
            r_idx      <= n_idx;
            r_len_acc  <= n_len_acc;
            r_off_acc  <= n_off_acc;
            r_prev     <= n_prev;
        end
    end

endmodule

@@ sv/data_run_list_decoder_top.sv @@
// a word taken into the input register goes through the parser and lands in the result register, which drives o_valid
// throughput: one byte per cycle while the result is not held; each byte takes one pass through the field merge
// and the 64-bit start cluster adder between the input and result registers
// a held result does not block the input register, which takes one more word
// reset: synchronous active-low i_rst_n empties both registers and returns the
// parser to the header state with a zero running start cluster
module data_run_list_decoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [drl_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [drl_pkg::START_W-1:0]  o_start_cluster,
    output logic [drl_pkg::COUNT_W-1:0]  o_cluster_count,
    output logic [drl_pkg::CODE_W-1:0]   o_end_code,
    output logic                         o_list_done
);
    import drl_pkg::*;

`include "data_run_list_decoder_top_defines.svh"

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_res;
    logic              w_go;
    logic              w_fire;

    // the result register can take a new value unless it is held
    assign w_go    = !(r_out_valid && i_stall);
    assign w_fire  = r_in_valid && w_go;
    assign o_stall = r_in_valid && !w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    drl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_start_cluster = r_out.run_start;
    assign o_cluster_count = r_out.run_length;
    assign o_end_code      = r_out.end_code;
    assign o_list_done     = r_out.list_done;

    `DRL_ASSERT_NOW(a_end_is_done, i_clk, i_rst_n, w_res.valid && w_res.end_code != END_RUN, w_res.list_done)
    `DRL_ASSERT_NOW(a_end_no_payload, i_clk, i_rst_n, w_res.valid && w_res.end_code != END_RUN, w_res.run_start == '0 && w_res.run_length == '0)
    `DRL_ASSERT_NOW(a_stall_needs_word, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid)
    `DRL_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_fire && w_res.valid, o_valid)

endmodule
